### rtl/core/hpt_pkg.sv
// ----------------------------------------------------------------------------
// hpt_pkg
// shared widths, register indexes, types and helper functions of the
// homogeneous point transform
// ----------------------------------------------------------------------------
package hpt_pkg;

    localparam int FRAC_BITS = 16;                 // fraction bits of the fixed-point format
    localparam int XW        = 32;                 // coordinate and matrix entry width
    localparam int CFGW      = 2 * XW;             // configuration register width
    localparam int NREG      = 8;                  // configuration registers
    localparam int IDXW      = 4;                  // register index port width
    localparam int RIDXW     = $clog2(NREG);       // bits that address a register
    localparam int PW        = 2 * XW;             // product width
    localparam int SW        = PW + 2;             // sum of three products and translation
    localparam int CW        = SW + 1 - FRAC_BITS; // coordinate before division
    localparam int QBITS     = XW + 1;             // quotient bits kept by the divider
    localparam int NW        = CW + FRAC_BITS;     // scaled dividend width
    localparam int DIV_LAT   = QBITS + 1;          // register stages of the divider
    localparam int LATENCY   = DIV_LAT + 4;        // registers from start to the done strobe

    localparam logic [XW-1:0] ONE_FX  = XW'(1) << FRAC_BITS;
    localparam logic [XW-1:0] FX_MAX  = {1'b0, {(XW-1){1'b1}}};
    localparam logic [XW-1:0] FX_MIN  = {1'b1, {(XW-1){1'b0}}};

    // register indexes
    localparam logic [IDXW-1:0] REG_COL0_ROWS01 = IDXW'(0);
    localparam logic [IDXW-1:0] REG_COL0_ROWS23 = IDXW'(1);
    localparam logic [IDXW-1:0] REG_COL1_ROWS01 = IDXW'(2);
    localparam logic [IDXW-1:0] REG_COL1_ROWS23 = IDXW'(3);
    localparam logic [IDXW-1:0] REG_COL2_ROWS01 = IDXW'(4);
    localparam logic [IDXW-1:0] REG_COL2_ROWS23 = IDXW'(5);
    localparam logic [IDXW-1:0] REG_COL3_ROWS01 = IDXW'(6);
    localparam logic [IDXW-1:0] REG_COL3_ROWS23 = IDXW'(7);

    typedef logic signed [XW-1:0] fx_t;
    typedef fx_t [3:0][3:0]       mat_t;   // [column][row]
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [SW-1:0] sum_t;
    typedef logic signed [CW-1:0] acc_t;
    typedef logic [CW-1:0]        mag_t;
    typedef logic [QBITS-1:0]     quo_t;

    typedef struct packed {
        logic            valid;
        logic            last;
        acc_t [3:0]      c;       // rows 0..2 and w
    } mac_t;

    typedef struct packed {
        logic            valid;
        logic            last;
        logic            proj;
        logic [2:0]      neg;
        fx_t  [2:0]      byp;     // saturated undivided coordinates
    } side_t;

    function automatic fx_t sat_fx(input acc_t v);
        fx_t res;
        if (v > acc_t'($signed(FX_MAX)))
            res = fx_t'(FX_MAX);
        else if (v < acc_t'($signed(FX_MIN)))
            res = fx_t'(FX_MIN);
        else
            res = fx_t'(v);
        return res;
    endfunction

    function automatic fx_t quo_fx(input quo_t q, input logic ovf, input logic neg);
        fx_t res;
        if (neg) begin
            if (ovf || q > quo_t'(FX_MIN))
                res = fx_t'(FX_MIN);
            else
                res = fx_t'(XW'(0) - q[XW-1:0]);
        end else begin
            if (ovf || q[QBITS-1] || q[XW-1])
                res = fx_t'(FX_MAX);
            else
                res = fx_t'(q[XW-1:0]);
        end
        return res;
    endfunction

    function automatic mag_t abs_acc(input acc_t v);
        mag_t res;
        if (v[CW-1])
            res = mag_t'(-v);
        else
            res = mag_t'(v);
        return res;
    endfunction

endpackage

### rtl/core/hpt_mac.sv
// ----------------------------------------------------------------------------
// hpt_mac
// two-stage matrix-vector product: products, then row sums with translation
// ----------------------------------------------------------------------------
module hpt_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_last,
    input  hpt_pkg::fx_t [2:0]  pt,
    input  hpt_pkg::mat_t       mat,
    output hpt_pkg::mac_t       res
);

    logic                 v1_reg;
    logic                 l1_reg;
    hpt_pkg::prod_t       prod_reg [3][4];
    hpt_pkg::mac_t        res_reg;
    hpt_pkg::mac_t        res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            res_reg <= '0;
        end
        else
        begin
            v1_reg  <= in_valid;
            res_reg <= res_next;
        end
    end

    // stage 1: twelve products
    always_ff @(posedge clk)
    begin
        l1_reg <= in_last;
        for (int c = 0; c < 3; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                prod_reg[c][r] <= hpt_pkg::prod_t'(mat[c][r]) * hpt_pkg::prod_t'(pt[c]);
            end
        end
    end

    // stage 2: exact sum, floor to the fixed-point grid
    always_comb
    begin
        hpt_pkg::sum_t s;
        res_next       = '0;
        res_next.valid = v1_reg;
        res_next.last  = l1_reg;
        for (int r = 0; r < 4; r++)
        begin
            s = hpt_pkg::sum_t'(prod_reg[0][r]) + hpt_pkg::sum_t'(prod_reg[1][r])
              + hpt_pkg::sum_t'(prod_reg[2][r])
              + (hpt_pkg::sum_t'(mat[3][r]) <<< hpt_pkg::FRAC_BITS);
            res_next.c[r] = hpt_pkg::acc_t'(s >>> hpt_pkg::FRAC_BITS);
        end
    end

    assign res = res_reg;

endmodule

### rtl/core/hpt_div.sv
// ----------------------------------------------------------------------------
// hpt_div
// pipelined restoring divider, one quotient bit per stage, unsigned magnitudes
// ----------------------------------------------------------------------------
module hpt_div (
    input  logic                clk,
    input  hpt_pkg::mag_t       num,
    input  hpt_pkg::mag_t       den,
    output hpt_pkg::quo_t       q,
    output logic                ovf
);

    localparam int QB = hpt_pkg::QBITS;
    localparam int CW = hpt_pkg::CW;

    hpt_pkg::mag_t   rem_reg  [QB+1];
    hpt_pkg::quo_t   bits_reg [QB+1];
    hpt_pkg::quo_t   q_reg    [QB+1];
    hpt_pkg::mag_t   den_reg  [QB+1];
    logic            ovf_reg  [QB+1];

    logic [hpt_pkg::NW-1:0] nfull;

    assign nfull = {num, {hpt_pkg::FRAC_BITS{1'b0}}};

    // entry stage: overflow check and first partial remainder
    always_ff @(posedge clk)
    begin
        ovf_reg[0]  <= (CW+QB)'(nfull) >= {den, {QB{1'b0}}};
        rem_reg[0]  <= CW'(nfull >> QB);
        bits_reg[0] <= nfull[QB-1:0];
        q_reg[0]    <= '0;
        den_reg[0]  <= den;
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [CW:0] trial;
        logic        take;

        assign trial = {rem_reg[k], bits_reg[k][QB-1]};
        assign take  = trial >= {1'b0, den_reg[k]};

        always_ff @(posedge clk)
        begin
            if (take)
                rem_reg[k+1] <= CW'(trial - {1'b0, den_reg[k]});
            else
                rem_reg[k+1] <= CW'(trial);
            bits_reg[k+1] <= {bits_reg[k][QB-2:0], 1'b0};
            q_reg[k+1]    <= {q_reg[k][QB-2:0], take};
            den_reg[k+1]  <= den_reg[k];
            ovf_reg[k+1]  <= ovf_reg[k];
        end
    end

    assign q   = q_reg[QB];
    assign ovf = ovf_reg[QB];

endmodule

### rtl/core/homogeneous_point_transform.sv
// ----------------------------------------------------------------------------
// homogeneous_point_transform
// 4x4 column-major homogeneous transform of Q16.16 points with optional
// perspective division by w and saturation to 32 bits
// ----------------------------------------------------------------------------
//  channel   signals                               transaction when
//  -------   -----------------------------------   -----------------------
//  point     start, x_in, y_in, z_in, last_in      start high, busy low
//  result    done, x_out, y_out, z_out,            done high (one cycle)
//            projected, last_out
//  config    cfg_we, cfg_idx, cfg_data             cfg_we high
//
//  one point enters every cycle; each result passes through 2 product/sum
//  stages, 1 prep stage, 34 divider stages (an entry stage plus 33 quotient
//  bits) and 1 output stage
//  busy stays low: the pipeline never stops
//  reset clears all valid bits and loads the identity matrix
//  results cannot be held off, so nothing inside ever stalls
// ----------------------------------------------------------------------------
module homogeneous_point_transform (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [31:0]          x_in,
    input  logic signed [31:0]          y_in,
    input  logic signed [31:0]          z_in,
    input  logic                        last_in,
    output logic                        done,
    output logic signed [31:0]          x_out,
    output logic signed [31:0]          y_out,
    output logic signed [31:0]          z_out,
    output logic                        projected,
    output logic                        last_out,
    input  logic                        cfg_we,
    input  logic [hpt_pkg::IDXW-1:0]    cfg_idx,
    input  logic [hpt_pkg::CFGW-1:0]    cfg_data
);

    localparam int XW = hpt_pkg::XW;

    // configuration registers, identity after reset
    logic [hpt_pkg::CFGW-1:0] cfg_reg [hpt_pkg::NREG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hpt_pkg::NREG; i++)
            begin
                cfg_reg[i] <= '0;
            end
            cfg_reg[hpt_pkg::REG_COL0_ROWS01[hpt_pkg::RIDXW-1:0]] <=
                hpt_pkg::CFGW'(hpt_pkg::ONE_FX);
            cfg_reg[hpt_pkg::REG_COL1_ROWS01[hpt_pkg::RIDXW-1:0]] <=
                {hpt_pkg::ONE_FX, {XW{1'b0}}};
            cfg_reg[hpt_pkg::REG_COL2_ROWS23[hpt_pkg::RIDXW-1:0]] <=
                hpt_pkg::CFGW'(hpt_pkg::ONE_FX);
            cfg_reg[hpt_pkg::REG_COL3_ROWS23[hpt_pkg::RIDXW-1:0]] <=
                {hpt_pkg::ONE_FX, {XW{1'b0}}};
        end
        else if (cfg_we && cfg_idx <= hpt_pkg::REG_COL3_ROWS23)
        begin
            // indexes past the last register are dropped
            cfg_reg[cfg_idx[hpt_pkg::RIDXW-1:0]] <= cfg_data;
        end
    end

    // matrix view: column c lives in registers 2c (rows 0,1) and 2c+1 (rows 2,3)
    hpt_pkg::mat_t mat;

    for (genvar c = 0; c < 4; c++)
    begin : g_col
        for (genvar r = 0; r < 4; r++)
        begin : g_row
            assign mat[c][r] = hpt_pkg::fx_t'(cfg_reg[c*2 + r/2][(r%2)*XW +: XW]);
        end
    end

    // bottom row exactly 0,0,0,1 means no perspective step
    logic plain;
    assign plain = mat[0][3] == '0 && mat[1][3] == '0 && mat[2][3] == '0
                && mat[3][3] == hpt_pkg::fx_t'(hpt_pkg::ONE_FX);

    assign busy = 1'b0;

    // products and row sums
    hpt_pkg::fx_t [2:0] pt;
    hpt_pkg::mac_t      mac;

    assign pt = {z_in, y_in, x_in};

    hpt_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .in_last  (last_in),
        .pt       (pt),
        .mat      (mat),
        .res      (mac)
    );

    // prep stage: signs, magnitudes, undivided fallback
    hpt_pkg::side_t side_next;
    hpt_pkg::side_t side_reg [hpt_pkg::DIV_LAT+1];
    hpt_pkg::mag_t  num_reg  [3];
    hpt_pkg::mag_t  den_reg;

    always_comb
    begin
        side_next       = '0;
        side_next.valid = mac.valid;
        side_next.last  = mac.last;
        side_next.proj  = !plain && mac.c[3] != '0;
        for (int i = 0; i < 3; i++)
        begin
            side_next.neg[i] = mac.c[i][hpt_pkg::CW-1] ^ mac.c[3][hpt_pkg::CW-1];
            side_next.byp[i] = hpt_pkg::sat_fx(mac.c[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_reg[i] <= hpt_pkg::abs_acc(mac.c[i]);
        end
        den_reg <= hpt_pkg::abs_acc(mac.c[3]);
    end

    // sideband line that runs beside the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= hpt_pkg::DIV_LAT; k++)
            begin
                side_reg[k] <= '0;
            end
        end
        else
        begin
            side_reg[0] <= side_next;
            for (int k = 0; k < hpt_pkg::DIV_LAT; k++)
            begin
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // one divider lane per coordinate, shared w
    hpt_pkg::quo_t q   [3];
    logic          ovf [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        hpt_div u_div (
            .clk (clk),
            .num (num_reg[i]),
            .den (den_reg),
            .q   (q[i]),
            .ovf (ovf[i])
        );
    end

    // output stage
    hpt_pkg::side_t     sd;
    hpt_pkg::fx_t [2:0] out_next;
    hpt_pkg::fx_t [2:0] out_reg;
    logic               done_reg;
    logic               proj_reg;
    logic               last_reg;

    assign sd = side_reg[hpt_pkg::DIV_LAT];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (sd.proj)
                out_next[i] = hpt_pkg::quo_fx(q[i], ovf[i], sd.neg[i]);
            else
                out_next[i] = sd.byp[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= sd.valid;
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        proj_reg <= sd.proj;
        last_reg <= sd.last;
    end

    assign done      = done_reg;
    assign x_out     = out_reg[0];
    assign y_out     = out_reg[1];
    assign z_out     = out_reg[2];
    assign projected = proj_reg;
    assign last_out  = last_reg;

endmodule

### rtl/core/hpt_checker.sv
// ----------------------------------------------------------------------------
// hpt_checker
// port-level checks of the point transform, bound to the top level
// ----------------------------------------------------------------------------
module hpt_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic                        last_in,
    input  logic                        done,
    input  logic                        projected,
    input  logic                        last_out
);

    // the pipeline never refuses a point
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // every result traces back to a point taken a fixed latency before
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, hpt_pkg::LATENCY))
        else $error("result without a matching point");

    // batch marker follows its point through the pipeline
    a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> last_out == $past(last_in, hpt_pkg::LATENCY))
        else $error("last_out does not match its point");

    // a point taken always produces a result a fixed latency later
    a_start_has_done: assert property (@(posedge clk) disable iff (!rst_n)
        $past(start && !busy, hpt_pkg::LATENCY) && $past(rst_n, hpt_pkg::LATENCY)
        |-> done)
        else $error("point lost");

    // flags of a result are always defined
    a_flags_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown({projected, last_out}))
        else $error("result flags unknown");

endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .last_in   (last_in),
    .done      (done),
    .projected (projected),
    .last_out  (last_out)
);
